// ----- design/mfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiplexer frame deframer package
// Shared types, protocol constants and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int CHANNELS_DEFAULT = 64;

  localparam logic [7:0] FLAG_BYTE = 8'hF9;
  localparam logic [7:0] CRC_INIT  = 8'hFF;
  localparam logic [7:0] CRC_GOOD  = 8'hCF;
  localparam logic [7:0] CRC_POLY  = 8'hE0;
  localparam logic [7:0] PF_BIT    = 8'h10;
  localparam logic [7:0] CTL_UI    = 8'h03;
  localparam logic [7:0] CTL_SABM  = 8'h2F;
  localparam logic [7:0] CTL_DISC  = 8'h43;
  localparam logic [7:0] CTL_DM    = 8'h0F;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CTRL  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_FCS   = 3'd5,
    PH_CLOSE = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_UA   = 2'd1,
    REPLY_DM   = 2'd2
  } reply_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [5:0]  dlci;
    logic [7:0]  control_byte;
    logic [6:0]  payload_length;
    reply_t      reply;
    logic [15:0] good_frames;
    logic [15:0] bad_frames;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [7:0] ctl_type;
    logic [5:0] dlci;
  } map_req_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/mfd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiplexer frame deframer channels
// Valid/ready channels for received bytes and for result beats.
// ----------------------------------------------------------------------------
interface mfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [5:0]  dlci;
  logic [7:0]  control_byte;
  logic [6:0]  payload_length;
  logic [1:0]  reply;
  logic [15:0] good_frames;
  logic [15:0] bad_frames;

  modport source (output valid, output kind, output payload_byte, output dlci,
                  output control_byte, output payload_length, output reply,
                  output good_frames, output bad_frames, input ready);
  modport sink (input valid, input kind, input payload_byte, input dlci,
                input control_byte, input payload_length, input reply,
                input good_frames, input bad_frames, output ready);
endinterface

// ----- design/mfd_chan_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel activity map
// One active flag per channel, updated by accepted SABM, DISC and DM frames.
// ----------------------------------------------------------------------------
module mfd_chan_map #(
  parameter int CHANNELS = mfd_pkg::CHANNELS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  mfd_pkg::map_req_t req,
  output mfd_pkg::reply_t   reply
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] active_next;
  logic [IDX_W-1:0]    idx;
  logic                inrange;
  logic                act;

  assign idx     = req.dlci[IDX_W-1:0];
  assign inrange = (int'(req.dlci) < CHANNELS);
  assign act     = inrange && active[idx];

  always_comb begin
    active_next = active;
    reply       = mfd_pkg::REPLY_NONE;
    unique case (req.ctl_type)
      mfd_pkg::CTL_SABM: begin
        reply = mfd_pkg::REPLY_UA;
        if (inrange) active_next[idx] = 1'b1;
      end
      mfd_pkg::CTL_DISC: begin
        if (act) begin
          reply            = mfd_pkg::REPLY_UA;
          active_next[idx] = 1'b0;
        end else begin
          reply = mfd_pkg::REPLY_DM;
        end
      end
      mfd_pkg::CTL_DM: begin
        if (inrange) active_next[idx] = 1'b0;
      end
      default: begin
        reply = mfd_pkg::REPLY_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (req.en) begin
      active <= active_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (req.en && req.ctl_type == mfd_pkg::CTL_SABM && inrange) |=> active[$past(idx)])
    else $error("SABM did not mark the channel active");

endmodule

// ----- design/mfd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Phase sequencer, CRC check and frame counters, one received byte per beat.
// ----------------------------------------------------------------------------
module mfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        rx_byte,
  output mfd_pkg::map_req_t map_req,
  input  mfd_pkg::reply_t   map_reply,
  output logic              res_valid,
  output mfd_pkg::result_t  res
);

  mfd_pkg::phase_t phase, phase_next;
  logic [5:0]  frame_dlci, frame_dlci_next;
  logic [7:0]  frame_control, frame_control_next;
  logic [6:0]  frame_length, frame_length_next;
  logic [6:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] accepted_count, accepted_count_next;
  logic [15:0] drop_count, drop_count_next;
  logic [7:0]  ctl_type;
  logic [7:0]  crc_upd;
  logic        is_flag;

  assign ctl_type = frame_control & ~mfd_pkg::PF_BIT;
  assign crc_upd  = mfd_pkg::crc8_step(running_crc, rx_byte);
  assign is_flag  = (rx_byte == mfd_pkg::FLAG_BYTE);

  always_comb begin
    phase_next          = phase;
    frame_dlci_next     = frame_dlci;
    frame_control_next  = frame_control;
    frame_length_next   = frame_length;
    bytes_left_next     = bytes_left;
    running_crc_next    = running_crc;
    accepted_count_next = accepted_count;
    drop_count_next     = drop_count;
    res_valid           = 1'b0;
    res.kind            = mfd_pkg::KIND_PAYLOAD;
    res.payload_byte    = 8'h00;
    res.reply           = mfd_pkg::REPLY_NONE;
    map_req.en          = 1'b0;
    map_req.ctl_type    = ctl_type;
    map_req.dlci        = frame_dlci;
    unique case (phase)
      mfd_pkg::PH_ADDR: begin
        if (!is_flag) begin
          frame_dlci_next  = rx_byte[7:2];
          running_crc_next = mfd_pkg::crc8_step(mfd_pkg::CRC_INIT, rx_byte);
          phase_next       = mfd_pkg::PH_CTRL;
        end
      end
      mfd_pkg::PH_CTRL: begin
        frame_control_next = rx_byte;
        running_crc_next   = crc_upd;
        phase_next         = mfd_pkg::PH_LEN;
      end
      mfd_pkg::PH_LEN: begin
        running_crc_next  = crc_upd;
        frame_length_next = rx_byte[7:1];
        if (!rx_byte[0]) begin
          phase_next = mfd_pkg::PH_HUNT;
        end else begin
          bytes_left_next = rx_byte[7:1];
          phase_next = (rx_byte[7:1] != 7'd0) ? mfd_pkg::PH_DATA : mfd_pkg::PH_FCS;
        end
      end
      mfd_pkg::PH_DATA: begin
        if (ctl_type == mfd_pkg::CTL_UI) running_crc_next = crc_upd;
        bytes_left_next = bytes_left - 7'd1;
        if (bytes_left_next == 7'd0) phase_next = mfd_pkg::PH_FCS;
        res_valid        = 1'b1;
        res.kind         = mfd_pkg::KIND_PAYLOAD;
        res.payload_byte = rx_byte;
      end
      mfd_pkg::PH_FCS: begin
        if (crc_upd != mfd_pkg::CRC_GOOD) begin
          drop_count_next = drop_count + 16'd1;
          phase_next = is_flag ? mfd_pkg::PH_ADDR : mfd_pkg::PH_HUNT;
          res_valid  = 1'b1;
          res.kind   = mfd_pkg::KIND_DROP;
        end else begin
          phase_next = mfd_pkg::PH_CLOSE;
        end
      end
      mfd_pkg::PH_CLOSE: begin
        res_valid = 1'b1;
        if (!is_flag) begin
          drop_count_next = drop_count + 16'd1;
          phase_next = mfd_pkg::PH_HUNT;
          res.kind   = mfd_pkg::KIND_DROP;
        end else begin
          accepted_count_next = accepted_count + 16'd1;
          map_req.en = in_fire;
          phase_next = mfd_pkg::PH_ADDR;
          res.kind   = mfd_pkg::KIND_ACCEPT;
          res.reply  = map_reply;
        end
      end
      default: begin
        phase_next = is_flag ? mfd_pkg::PH_ADDR : mfd_pkg::PH_HUNT;
      end
    endcase
    res.dlci           = frame_dlci;
    res.control_byte   = frame_control;
    res.payload_length = frame_length;
    res.good_frames    = accepted_count_next;
    res.bad_frames     = drop_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mfd_pkg::PH_HUNT;
      frame_dlci     <= '0;
      frame_control  <= '0;
      frame_length   <= '0;
      bytes_left     <= '0;
      running_crc    <= mfd_pkg::CRC_INIT;
      accepted_count <= '0;
      drop_count     <= '0;
    end else if (in_fire) begin
      phase          <= phase_next;
      frame_dlci     <= frame_dlci_next;
      frame_control  <= frame_control_next;
      frame_length   <= frame_length_next;
      bytes_left     <= bytes_left_next;
      running_crc    <= running_crc_next;
      accepted_count <= accepted_count_next;
      drop_count     <= drop_count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_valid && res.kind == mfd_pkg::KIND_ACCEPT) |=> phase == mfd_pkg::PH_ADDR)
    else $error("Closing flag did not reopen the next frame");

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == mfd_pkg::PH_DATA && bytes_left == 7'd1) |=> phase == mfd_pkg::PH_FCS)
    else $error("Last payload byte did not lead to the FCS byte");

endmodule

// ----- design/mfd_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid stage so the input side keeps moving.
// ----------------------------------------------------------------------------
module mfd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mfd_pkg::result_t push_data,
  output logic             can_accept,
  output logic             out_valid,
  input  logic             out_ready,
  output mfd_pkg::result_t out_data
);

  logic             ovalid;
  logic             svalid;
  mfd_pkg::result_t odata;
  mfd_pkg::result_t sdata;
  logic             pop;

  assign pop        = ovalid && out_ready;
  assign can_accept = !svalid;
  assign out_valid  = ovalid;
  assign out_data   = odata;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      svalid <= 1'b0;
    end else if (pop) begin
      if (svalid) begin
        svalid <= 1'b0;
      end else begin
        ovalid <= push;
      end
    end else if (push) begin
      if (!ovalid) begin
        ovalid <= 1'b1;
      end else begin
        svalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && svalid) begin
      odata <= sdata;
    end else if (push && (pop || !ovalid)) begin
      odata <= push_data;
    end
    if (push && ovalid && !pop) begin
      sdata <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) svalid |-> ovalid)
    else $error("Skid stage holds a beat while the output register is empty");

endmodule

// ----- design/mux_frame_deframer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiplexer frame deframer
// Basic-mode receive deframer with CRC-8 check and a per-channel active map.
// ----------------------------------------------------------------------------
// Usage: received bytes enter one per beat on the link channel. Each byte
// yields at most one beat on the events channel: a payload byte, a frame
// accepted (with the reply owed to the peer) or a frame dropped. Header,
// flag and FCS bytes that settle nothing give no beat.
// Each event beat is registered, in the output register or in the skid
// stage. Throughput is one byte per cycle while link ready holds: the phase
// step, the CRC byte update and the map lookup form one combinational pass
// between the byte handshake and the output register.
// When the receiver stalls, one further event is held in a skid stage and
// link ready then drops until the output register drains.
// Reset returns the parser to hunting for a flag, clears the counters and
// marks every channel inactive.
// ----------------------------------------------------------------------------
module mux_frame_deframer_top #(
  parameter int CHANNELS = mfd_pkg::CHANNELS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  mfd_byte_if.sink     link,
  mfd_result_if.source events
);

  logic              in_fire;
  logic              can_accept;
  logic              res_valid;
  mfd_pkg::result_t  res;
  mfd_pkg::result_t  out_data;
  mfd_pkg::map_req_t map_req;
  mfd_pkg::reply_t   map_reply;

  assign link.ready = can_accept;
  assign in_fire    = link.valid && can_accept;

  mfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .rx_byte   (link.rx_byte),
    .map_req   (map_req),
    .map_reply (map_reply),
    .res_valid (res_valid),
    .res       (res)
  );

  mfd_chan_map #(
    .CHANNELS (CHANNELS)
  ) u_chan_map (
    .clk   (clk),
    .rst   (rst),
    .req   (map_req),
    .reply (map_reply)
  );

  mfd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire && res_valid),
    .push_data  (res),
    .can_accept (can_accept),
    .out_valid  (events.valid),
    .out_ready  (events.ready),
    .out_data   (out_data)
  );

  assign events.kind           = out_data.kind;
  assign events.payload_byte   = out_data.payload_byte;
  assign events.dlci           = out_data.dlci;
  assign events.control_byte   = out_data.control_byte;
  assign events.payload_length = out_data.payload_length;
  assign events.reply          = out_data.reply;
  assign events.good_frames    = out_data.good_frames;
  assign events.bad_frames     = out_data.bad_frames;

endmodule

// ----- sim/deframe_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer monitor
// Watches the link and event channels of the deframer. It tracks the frame
// phase, the CRC-8, the channel map and the frame counters from the accepted
// link bytes. It then checks each event beat field by field against the
// oldest event still owed.
// ----------------------------------------------------------------------------
module deframe_monitor
  import mfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  mfd_byte_if   link,
  mfd_result_if events,
  output int    fail_count,
  output int    pending_results
);

  phase_t      phase;
  logic [5:0]  f_dlci;
  logic [7:0]  f_ctl;
  logic [6:0]  f_len;
  logic [6:0]  left;
  logic [7:0]  crc;
  logic        live [64];
  logic [15:0] good_count;
  logic [15:0] bad_count;
  result_t     owed_events [$];

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       lsb;
    r = acc ^ b;
    repeat (8) begin
      lsb = r[0];
      r = {1'b0, r[7:1]};
      if (lsb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic reply_t channel_action();
    logic [7:0] code;
    code = f_ctl & ~PF_BIT;
    if (code == CTL_SABM) begin
      live[f_dlci] = 1'b1;
      return REPLY_UA;
    end
    if (code == CTL_DISC) begin
      if (live[f_dlci]) begin
        live[f_dlci] = 1'b0;
        return REPLY_UA;
      end
      return REPLY_DM;
    end
    if (code == CTL_DM) live[f_dlci] = 1'b0;
    return REPLY_NONE;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    result_t ev;
    logic    owes;
    ev = '0;
    owes = 1'b0;
    case (phase)
      PH_ADDR: begin
        if (b != FLAG_BYTE) begin
          f_dlci = b[7:2];
          crc = crc8_next(CRC_INIT, b);
          phase = PH_CTRL;
        end
      end
      PH_CTRL: begin
        f_ctl = b;
        crc = crc8_next(crc, b);
        phase = PH_LEN;
      end
      PH_LEN: begin
        crc = crc8_next(crc, b);
        f_len = b[7:1];
        if (!b[0]) begin
          phase = PH_HUNT;
        end else begin
          left = b[7:1];
          if (left != 0) phase = PH_DATA;
          else phase = PH_FCS;
        end
      end
      PH_DATA: begin
        if ((f_ctl & ~PF_BIT) == CTL_UI) crc = crc8_next(crc, b);
        left = left - 7'd1;
        if (left == 0) phase = PH_FCS;
        ev.kind = KIND_PAYLOAD;
        ev.payload_byte = b;
        owes = 1'b1;
      end
      PH_FCS: begin
        if (crc8_next(crc, b) != CRC_GOOD) begin
          bad_count = bad_count + 16'd1;
          if (b == FLAG_BYTE) phase = PH_ADDR;
          else phase = PH_HUNT;
          ev.kind = KIND_DROP;
          owes = 1'b1;
        end else begin
          phase = PH_CLOSE;
        end
      end
      PH_CLOSE: begin
        if (b != FLAG_BYTE) begin
          bad_count = bad_count + 16'd1;
          phase = PH_HUNT;
          ev.kind = KIND_DROP;
        end else begin
          good_count = good_count + 16'd1;
          ev.reply = channel_action();
          ev.kind = KIND_ACCEPT;
          phase = PH_ADDR;
        end
        owes = 1'b1;
      end
      default: begin
        if (b == FLAG_BYTE) phase = PH_ADDR;
        else phase = PH_HUNT;
      end
    endcase
    if (owes) begin
      ev.dlci = f_dlci;
      ev.control_byte = f_ctl;
      ev.payload_length = f_len;
      ev.good_frames = good_count;
      ev.bad_frames = bad_count;
      owed_events.push_back(ev);
    end
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("kind %0d byte %02h dlci %0d ctl %02h len %0d reply %0d good %0d bad %0d",
                     r.kind, r.payload_byte, r.dlci, r.control_byte, r.payload_length,
                     r.reply, r.good_frames, r.bad_frames);
  endfunction

  function automatic void report(input string what, input result_t want, input result_t seen);
    fail_count = fail_count + 1;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", describe(want));
      $display("  actual   %s", describe(seen));
    end
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      phase = PH_HUNT;
      f_dlci = '0;
      f_ctl = '0;
      f_len = '0;
      left = '0;
      crc = CRC_INIT;
      foreach (live[i]) live[i] = 1'b0;
      good_count = '0;
      bad_count = '0;
      owed_events.delete();
      fail_count = 0;
    end else begin
      if (events.valid && events.ready) begin
        seen.kind = kind_t'(events.kind);
        seen.payload_byte = events.payload_byte;
        seen.dlci = events.dlci;
        seen.control_byte = events.control_byte;
        seen.payload_length = events.payload_length;
        seen.reply = reply_t'(events.reply);
        seen.good_frames = events.good_frames;
        seen.bad_frames = events.bad_frames;
        if (owed_events.size() == 0) begin
          report("event beat with nothing owed", '0, seen);
        end else begin
          want = owed_events.pop_front();
          if (seen.kind != want.kind || seen.payload_byte != want.payload_byte ||
              seen.dlci != want.dlci || seen.control_byte != want.control_byte ||
              seen.payload_length != want.payload_length || seen.reply != want.reply ||
              seen.good_frames != want.good_frames || seen.bad_frames != want.bad_frames)
            report("event beat differs", want, seen);
        end
      end
      if (link.valid && link.ready) deframe_byte(link.rx_byte);
    end
    pending_results = owed_events.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Feeds a short run of hand-built frames and then about eleven hundred bytes
// of random frames, broken frames and line noise into the deframer. The
// sender works in bursts and the receiver stalls, once for a long stretch.
// The monitor checks every event beat.
// ----------------------------------------------------------------------------
module tb;
  import mfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] CTL_UIH = 8'hEF;

  logic       clk = 1'b0;
  logic       rst;
  int         fail_count;
  int         pending_results;
  logic [7:0] link_bytes [$];

  mfd_byte_if   link_bus ();
  mfd_result_if event_bus ();

  mux_frame_deframer_top uut (
    .clk    (clk),
    .rst    (rst),
    .link   (link_bus),
    .events (event_bus)
  );

  deframe_monitor monitor (
    .clk             (clk),
    .rst             (rst),
    .link            (link_bus),
    .events          (event_bus),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic add_frame(input logic [7:0] addr, input logic [7:0] ctl, input int len,
                           input bit spoil, input logic [7:0] spoilt);
    logic [7:0] acc;
    logic [7:0] b;
    logic [7:0] fcs;
    logic [6:0] n;
    n = len[6:0];
    acc = crc8_step(CRC_INIT, addr);
    acc = crc8_step(acc, ctl);
    acc = crc8_step(acc, {n, 1'b1});
    link_bytes.push_back(addr);
    link_bytes.push_back(ctl);
    link_bytes.push_back({n, 1'b1});
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if ((ctl & ~PF_BIT) == CTL_UI) acc = crc8_step(acc, b);
      link_bytes.push_back(b);
    end
    fcs = ~acc;
    if (spoil) fcs = (spoilt == fcs) ? (fcs ^ 8'h01) : spoilt;
    link_bytes.push_back(fcs);
  endtask

  task automatic build_stimulus();
    int         target;
    int         pick;
    int         len;
    logic [5:0] dlci;
    logic [7:0] addr;
    logic [7:0] ctl;
    logic [7:0] b;
    // Hand-built frames: hunting, repeated flags, each frame type and each way to fail.
    link_bytes.push_back(8'h00);
    link_bytes.push_back(FLAG_BYTE);
    link_bytes.push_back(FLAG_BYTE);
    add_frame(8'h07, CTL_SABM | PF_BIT, 0, 1'b0, 8'h00);
    link_bytes.push_back(FLAG_BYTE);
    add_frame(8'h07, CTL_DISC, 0, 1'b0, 8'h00);
    link_bytes.push_back(FLAG_BYTE);
    add_frame(8'h07, CTL_DISC | PF_BIT, 0, 1'b0, 8'h00);
    link_bytes.push_back(FLAG_BYTE);
    add_frame(8'hFF, CTL_UI, 2, 1'b0, 8'h00);
    link_bytes.push_back(FLAG_BYTE);
    add_frame(8'h0B, CTL_DM | PF_BIT, 0, 1'b0, 8'h00);
    link_bytes.push_back(FLAG_BYTE);
    link_bytes.push_back(8'h0B);
    link_bytes.push_back(CTL_SABM);
    link_bytes.push_back(8'h00);
    link_bytes.push_back(FLAG_BYTE);
    add_frame(8'h0B, CTL_UIH, 1, 1'b1, FLAG_BYTE);
    add_frame(8'h0F, CTL_SABM, 0, 1'b0, 8'h00);
    link_bytes.push_back(8'h00);

    target = link_bytes.size() + 1100;
    while (link_bytes.size() < target) begin
      if (link_bytes[$] != FLAG_BYTE) link_bytes.push_back(FLAG_BYTE);
      pick = $urandom_range(0, 99);
      dlci = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 5));
      addr = {dlci, 2'($urandom_range(0, 3))};
      case ($urandom_range(0, 5))
        0: ctl = CTL_SABM;
        1: ctl = CTL_DISC;
        2: ctl = CTL_DM;
        3: ctl = CTL_UI;
        4: ctl = CTL_UIH;
        default: ctl = 8'($urandom);
      endcase
      if ($urandom_range(0, 1) == 1) ctl = ctl | PF_BIT;
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
      if (pick < 72) begin
        add_frame(addr, ctl, len, 1'b0, 8'h00);
        link_bytes.push_back(FLAG_BYTE);
        if ($urandom_range(0, 5) == 0) link_bytes.push_back(FLAG_BYTE);
      end else if (pick < 82) begin
        b = ($urandom_range(0, 2) == 0) ? FLAG_BYTE : 8'($urandom);
        add_frame(addr, ctl, len, 1'b1, b);
      end else if (pick < 88) begin
        add_frame(addr, ctl, len, 1'b0, 8'h00);
        b = 8'($urandom);
        if (b == FLAG_BYTE) b = b ^ 8'h01;
        link_bytes.push_back(b);
      end else if (pick < 93) begin
        link_bytes.push_back(addr);
        link_bytes.push_back(ctl);
        link_bytes.push_back({7'(len), 1'b0});
      end else begin
        repeat ($urandom_range(1, 8)) link_bytes.push_back(8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int burst;
    int gap;
    int idx;
    rst = 1'b1;
    link_bus.valid <= 1'b0;
    link_bus.rx_byte <= 8'h00;
    build_stimulus();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idx = 0;
    while (idx < link_bytes.size()) begin
      burst = $urandom_range(1, 48);
      while (burst > 0 && idx < link_bytes.size()) begin
        link_bus.valid <= 1'b1;
        link_bus.rx_byte <= link_bytes[idx];
        do @(posedge clk); while (!link_bus.ready);
        @(negedge clk);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        link_bus.valid <= 1'b0;
        link_bus.rx_byte <= 8'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    link_bus.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : event_sink
    int hold;
    int span;
    int mode;
    event_bus.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    event_bus.ready <= 1'b1;
    repeat (150) @(negedge clk);
    // A long hold-off while bytes keep coming, so that the block fills and backs up.
    event_bus.ready <= 1'b0;
    hold = 0;
    while (hold < 300) begin
      @(negedge clk);
      hold++;
    end
    forever begin
      mode = $urandom_range(0, 9);
      span = $urandom_range(5, 60);
      repeat (span) begin
        if (mode < 4) event_bus.ready <= 1'b1;
        else if (mode < 8) event_bus.ready <= ($urandom_range(0, 3) != 0);
        else if (mode == 8) event_bus.ready <= 1'($urandom_range(0, 1));
        else event_bus.ready <= 1'b0;
        @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mfd_pkg.sv
design/mfd_if.sv
design/mfd_chan_map.sv
design/mfd_parser.sv
design/mfd_out_buf.sv
design/mux_frame_deframer_top.sv
sim/deframe_monitor.sv
sim/tb.sv
